/* rtl/core/cocktail_shaker_sorter_core_defines.svh */
// assertion macros for the cocktail shaker sorter checker
`ifndef COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH
`define COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH
// concurrent check on clk, switched off while rst is high
`define CSS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// concurrent check on clk that also holds through reset
`define CSS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/core/csort_pkg.sv */
// shared constants and types of the cocktail shaker sorter
`default_nettype none
package csort_pkg;
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     end_set;
  } item_t;
endpackage
`default_nettype wire

/* rtl/core/csort_front.sv */
// front end: takes items, marks the end of each set, queues them for the back end
`default_nettype none
module csort_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  wire signed [31:0]          value,
  input  wire                        last_in,
  output logic                       q_valid,
  output csort_pkg::item_t           q_data,
  input  wire                        q_pop
);
  import csort_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [IDX_W-1:0]  set_count;
  logic              do_push;
  logic              do_pop;
  logic              set_end;

  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = queue[rd_ptr];
  // set ends on the flag or on the item that fills the store
  assign set_end = last_in || (set_count == IDX_W'(DEPTH - 1));

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= '{value: value, end_set: set_end};
    end
  end

  // pointers, fill level and per-set count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      set_count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr    <= wr_ptr + 1'b1;
        set_count <= set_end ? '0 : set_count + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/csort_back.sv */
// back end: loads a set, sorts it with transposition passes, shifts it out
`default_nettype none
module csort_back (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        q_valid,
  input  csort_pkg::item_t           q_data,
  output logic                       q_pop,
  output logic                       empty,
  input  wire                        pop,
  output logic signed [31:0]         sorted_value,
  output logic                       last_out
);
  import csort_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]               state;
  logic signed [DATA_W-1:0] store [DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         phase;

  assign q_pop        = (state == S_LOAD) && q_valid;
  assign empty        = (state != S_EMIT);
  assign sorted_value = store[0];
  assign last_out     = (count == CNT_W'(1));

  // element store: load, compare-exchange lanes, shift out
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (q_valid) begin
          store[count[IDX_W-1:0]] <= q_data.value;
        end
      end
      S_SORT: begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          if ((k % 2) == int'(phase[0]) && (k + 1) < int'(count) &&
              store[k] > store[k+1]) begin
            store[k]   <= store[k+1];
            store[k+1] <= store[k];
          end
        end
      end
      S_EMIT: begin
        if (pop) begin
          for (int k = 0; k < DEPTH - 1; k++) begin
            store[k] <= store[k+1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            count <= count + 1'b1;
            phase <= '0;
            if (q_data.end_set) begin
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          phase <= phase + 1'b1;
          if (phase == count - 1'b1) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            count <= count - 1'b1;
            if (count == CNT_W'(1)) begin
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/cocktail_shaker_sorter_core.sv */
// Loading: the back end writes each item into the store as it takes it from the queue, one
// item per cycle while the queue holds items; the item that ends a set starts the sort.
// Sorting: alternating even and odd passes of the compare-exchange lanes, then one result
// per cycle while pop is high; no new set is loaded until the last result is out.
// A four-entry queue lets the front take items while the back end sorts or shifts out.
// Reset (rst, synchronous): queue, counts and sequencer cleared; store contents left as is.
`default_nettype none
module cocktail_shaker_sorter_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  wire signed [31:0]   value,
  input  wire                 last_in,
  output logic                empty,
  input  wire                 pop,
  output logic signed [31:0]  sorted_value,
  output logic                last_out
);
  import csort_pkg::*;

  logic  q_valid;
  item_t q_data;
  logic  q_pop;

  // front end and item queue
  csort_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .value(value),
    .last_in(last_in), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  // sort engine
  csort_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .empty(empty), .pop(pop), .sorted_value(sorted_value), .last_out(last_out)
  );
endmodule
`default_nettype wire

/* rtl/core/csort_checker.sv */
// port checker for the sorter, bound to the top level
`default_nettype none
`include "cocktail_shaker_sorter_core_defines.svh"
module csort_checker (
  input wire                clk,
  input wire                rst,
  input wire                empty,
  input wire                pop,
  input wire signed [31:0]  sorted_value,
  input wire                last_out
);
  // nothing to take straight after reset
  `CSS_CHECK_ALWAYS(a_reset_empty, rst |=> empty, "result queue not empty after reset")
  // results of one set come out in ascending order with no gap
  `CSS_CHECK(a_ascending, (!empty && pop && !last_out) |=> (!empty && sorted_value >= $past(sorted_value)), "results out of order")
  // a waiting result holds until its transfer
  `CSS_CHECK(a_hold, (!empty && !pop) |=> (!empty && $stable(sorted_value) && $stable(last_out)), "waiting result changed")
endmodule

bind cocktail_shaker_sorter_core csort_checker u_csort_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop),
  .sorted_value(sorted_value), .last_out(last_out)
);
`default_nettype wire

/* tb/cocktail_shaker_sorter_checker.sv */
// checker for the cocktail shaker sorter: predicts sorted sets and compares results
`timescale 1ns / 1ps
`default_nettype none
module cocktail_shaker_sorter_checker
  import csort_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire                full,
  input  wire signed [31:0]  value,
  input  wire                last_in,
  input  wire                empty,
  input  wire                pop,
  input  wire signed [31:0]  sorted_value,
  input  wire                last_out,
  output int                 fail_count,
  output int                 pending,
  output int                 sets_seen,
  output int                 results_seen
);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sorted_t;

  logic signed [DATA_W-1:0] set_buf [$];
  sorted_t                  sorted_q [$];

  // sort the collected set ascending and queue one expectation per element
  task automatic emit_sorted_set();
    logic signed [DATA_W-1:0] arr [$];
    logic signed [DATA_W-1:0] t;
    sorted_t                  s;
    int                       n;
    begin
      arr = set_buf;
      n = arr.size();
      for (int a = 0; a < n; a++)
        for (int b = 0; b < n - 1 - a; b++)
          if (arr[b] > arr[b+1]) begin
            t = arr[b];
            arr[b] = arr[b+1];
            arr[b+1] = t;
          end
      for (int k = 0; k < n; k++) begin
        s.value = arr[k];
        s.last = (k == n - 1);
        sorted_q.push_back(s);
      end
      set_buf.delete();
      sets_seen++;
    end
  endtask

  task automatic report_mismatch(input string what);
    begin
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    sets_seen = 0;
    results_seen = 0;
  end

  // watch both transfers at every clock edge
  always @(posedge clk) begin
    sorted_t e;
    if (rst) begin
      set_buf.delete();
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", sorted_value));
        end else begin
          e = sorted_q.pop_front();
          if (sorted_value !== e.value)
            report_mismatch($sformatf("sorted_value %0d, wanted %0d", sorted_value, e.value));
          if (last_out !== e.last)
            report_mismatch($sformatf("last_out %0b, wanted %0b", last_out, e.last));
        end
      end
      if (push && !full) begin
        set_buf.push_back(value);
        if (last_in || set_buf.size() == DEPTH)
          emit_sorted_set();
      end
    end
    pending = sorted_q.size();
  end

endmodule
`default_nettype wire

/* tb/cocktail_shaker_sorter_core_tb.sv */
// testbench top: stimulus, idling phases and verdict for the cocktail shaker sorter
`timescale 1ns / 1ps
`default_nettype none
module cocktail_shaker_sorter_core_tb;
  import csort_pkg::*;

  logic               clk;
  logic               rst;
  logic               push;
  logic signed [31:0] value;
  logic               last_in;
  logic               pop;
  wire                full;
  wire                empty;
  wire signed [31:0]  sorted_value;
  wire                last_out;
  int                 fail_count;
  int                 pending;
  int                 sets_seen;
  int                 results_seen;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 hold_off;
  bit                 stim_done;
  int                 items_sent;

  cocktail_shaker_sorter_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .value(value), .last_in(last_in),
    .empty(empty), .pop(pop), .sorted_value(sorted_value), .last_out(last_out)
  );

  cocktail_shaker_sorter_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .value(value), .last_in(last_in),
    .empty(empty), .pop(pop), .sorted_value(sorted_value), .last_out(last_out),
    .fail_count(fail_count), .pending(pending), .sets_seen(sets_seen),
    .results_seen(results_seen)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one item and hold it until the transfer
  task automatic send_item(input logic signed [31:0] v, input logic l);
    begin
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push <= 1'b1;
      value <= v;
      last_in <= l;
      @(posedge clk);
      while (full) @(posedge clk);
      items_sent++;
    end
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: rand_value = 32'sh7fffffff - $urandom_range(3);
      1: rand_value = 32'sh80000000 + $urandom_range(3);
      2: rand_value = $urandom_range(7) - 4;
      default: rand_value = $urandom;
    endcase
  endfunction

  // a set of the given size with random content
  task automatic send_set(input int n);
    begin
      for (int k = 0; k < n; k++)
        send_item(rand_value(), k == n - 1);
    end
  endtask

  // receiver: pops at random unless a long hold-off is running
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_off && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    hold_off = 1'b0;
    wait (items_sent > 60);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // stimulus
  initial begin
    rst = 1'b1;
    push = 1'b0;
    value = '0;
    last_in = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stim_done = 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: single elements, extremes, equal values, full store ending a set
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b1);
    send_item(5, 1'b0);
    send_item(5, 1'b1);
    for (int k = 0; k < DEPTH; k++)
      send_item(DEPTH - k, 1'b0);

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 68) : 0;
      recv_stall_pct = (ph == 2) ? 68 : ((ph == 3) ? 8 : 0);
      for (int s = 0; s < 10; s++)
        send_set(($urandom_range(9) == 0) ? DEPTH : $urandom_range(1, 12));
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    recv_stall_pct = 0;
    while (pending != 0 || hold_off) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d items in %0d sets, %0d results checked", items_sent, sets_seen,
      results_seen);
    $display("phases: free running, idle sender, stalling receiver, mixed, long hold-off");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
